// File: src/sth_pkg.sv
// Package for the sequence-tagged frame history unit.
// Holds field widths, operation codes, default sizes and the store event type.
// No dependencies.
`default_nettype none

package sth_pkg;

  localparam int unsigned DEFAULT_HISTORY_DEPTH = 16;
  localparam int unsigned DEFAULT_FRAME_BYTES   = 36;

  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic first;
    logic last;
  } wr_evt_t;

endpackage

`default_nettype wire

// File: src/sequence_tagged_frame_history_unit.sv
// Top level of the sequence-tagged frame history unit: tag memory, valid bits and lookup sequencer.
// Instantiates sth_frame_buf; depends on sth_pkg.
//
//   channel   ports                          transfer
//   input     start, busy, op, seq, data_byte start high and busy low at a rising edge
//   result    strobe, found, out_byte, last   strobe high for one cycle, always taken
//
// A store does not raise busy, so frame bytes can arrive on every cycle while no lookup is in progress.
// A lookup scans the tag memory one slot per cycle, then on a hit reads the frame memory one byte
// per cycle; busy stays high until the last result is issued, and the single read port of each
// memory sets this pace.
// Synchronous reset clears the valid bits and the write position; there is no clearing pass.
// Results cannot be held off by the receiver.
`default_nettype none

module sequence_tagged_frame_history_unit #(
  parameter int unsigned HISTORY_DEPTH = sth_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int unsigned FRAME_BYTES   = sth_pkg::DEFAULT_FRAME_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic [sth_pkg::SEQ_W-1:0]  seq,
  input  wire logic [sth_pkg::BYTE_W-1:0] data_byte,
  output logic                            strobe,
  output logic                            found,
  output logic      [sth_pkg::BYTE_W-1:0] out_byte,
  output logic                            last
);
  import sth_pkg::*;

  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned ADDR_W = $clog2(HISTORY_DEPTH * FRAME_BYTES);
  localparam int unsigned POS_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

  state_t             state;
  logic               store_acc;
  logic               lookup_acc;
  logic [SLOT_W-1:0]  wr_slot;
  wr_evt_t            wr_evt;
  logic [HISTORY_DEPTH-1:0] valid;

  logic [SEQ_W-1:0]   tag_mem [HISTORY_DEPTH];
  logic [SEQ_W-1:0]   tag_q;
  logic [SLOT_W-1:0]  tag_rd_addr;
  logic [SEQ_W-1:0]   seq_q;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  idx_next;
  logic               idx_end;
  logic               hit;
  logic [ADDR_W-1:0]  srch_base;
  logic [ADDR_W-1:0]  strm_addr;
  logic [ADDR_W-1:0]  fr_rd_addr;
  logic [BYTE_W-1:0]  fr_q;
  logic [POS_W-1:0]   cnt;
  logic               cnt_end;

  assign busy       = (state != ST_IDLE);
  assign store_acc  = start && !busy && (op == OP_STORE);
  assign lookup_acc = start && !busy && (op == OP_LOOKUP);

  assign idx_end  = (idx == SLOT_W'(HISTORY_DEPTH - 1));
  assign idx_next = idx_end ? '0 : idx + 1'b1;
  assign hit      = valid[idx] && (tag_q == seq_q);
  assign cnt_end  = (cnt == POS_W'(FRAME_BYTES - 1));

  assign tag_rd_addr = (state == ST_SEARCH) ? idx_next : '0;

  always_comb begin
    unique case (state)
      ST_STREAM: fr_rd_addr = cnt_end ? strm_addr : strm_addr + 1'b1;
      default:   fr_rd_addr = srch_base;
    endcase
  end

  sth_frame_buf #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_frame_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_acc),
    .wr_byte (data_byte),
    .rd_addr (fr_rd_addr),
    .rd_data (fr_q),
    .wr_slot (wr_slot),
    .wr_evt  (wr_evt)
  );

  always_ff @(posedge clk) begin
    if (store_acc && wr_evt.last) begin
      tag_mem[wr_slot] <= seq;
    end
    tag_q <= tag_mem[tag_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (store_acc) begin
      if (wr_evt.last) begin
        valid[wr_slot] <= 1'b1;
      end else if (wr_evt.first) begin
        valid[wr_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      seq_q <= seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      srch_base <= '0;
      strm_addr <= '0;
      cnt       <= '0;
      strobe    <= 1'b0;
      found     <= 1'b0;
      out_byte  <= '0;
      last      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (lookup_acc) begin
            idx       <= '0;
            srch_base <= '0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            strm_addr <= srch_base;
            cnt       <= '0;
            state     <= ST_STREAM;
          end else if (idx_end) begin
            strobe   <= 1'b1;
            found    <= 1'b0;
            out_byte <= '0;
            last     <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            idx       <= idx_next;
            srch_base <= srch_base + ADDR_W'(FRAME_BYTES);
          end
        end
        ST_STREAM: begin
          strobe   <= 1'b1;
          found    <= 1'b1;
          out_byte <= fr_q;
          last     <= cnt_end;
          if (cnt_end) begin
            state <= ST_IDLE;
          end else begin
            cnt       <= cnt + 1'b1;
            strm_addr <= strm_addr + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/sth_frame_buf.sv
// Frame byte memory with the ring write position (slot, byte position, base address).
// Reports where the next stored byte falls within its frame.
// Depends on sth_pkg.
`default_nettype none

module sth_frame_buf #(
  parameter int unsigned HISTORY_DEPTH = sth_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int unsigned FRAME_BYTES   = sth_pkg::DEFAULT_FRAME_BYTES,
  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH),
  localparam int unsigned ADDR_W = $clog2(HISTORY_DEPTH * FRAME_BYTES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [sth_pkg::BYTE_W-1:0] wr_byte,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [sth_pkg::BYTE_W-1:0] rd_data,
  output logic      [SLOT_W-1:0]          wr_slot,
  output sth_pkg::wr_evt_t                wr_evt
);
  import sth_pkg::*;

  localparam int unsigned MEM_DEPTH = HISTORY_DEPTH * FRAME_BYTES;
  localparam int unsigned POS_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic [BYTE_W-1:0] frame_mem [MEM_DEPTH];
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] wr_base;
  logic [ADDR_W-1:0] wr_addr;
  logic              slot_wrap;

  assign wr_evt.first = (pos == '0);
  assign wr_evt.last  = (pos == POS_W'(FRAME_BYTES - 1));
  assign wr_addr      = wr_base + ADDR_W'(pos);
  assign slot_wrap    = (wr_slot == SLOT_W'(HISTORY_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_byte;
    end
    rd_data <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wr_slot <= '0;
      wr_base <= '0;
    end else if (wr_en) begin
      if (wr_evt.last) begin
        pos <= '0;
        if (slot_wrap) begin
          wr_slot <= '0;
          wr_base <= '0;
        end else begin
          wr_slot <= wr_slot + 1'b1;
          wr_base <= wr_base + ADDR_W'(FRAME_BYTES);
        end
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
